// ===== hdl/plc_pkg.sv =====
package plc_pkg;

   localparam int SLOTS_DEF = 32;

   localparam int MODE_W = 3;
   localparam int BLK_W  = 32;
   localparam int SLOT_W = 5;
   localparam int KIND_W = 3;
   localparam int CNT_W  = 16;

   // req tdata: block_number, slot; rsp tdata: slot_res, block_out, dirty_answer
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_REQUEST = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRBACK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MARK    = 3'd5;

   localparam logic [KIND_W-1:0] KIND_HIT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STORE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

endpackage

// ===== hdl/pinned_lru_block_cache_control.sv =====
// Tag and control store of a fully associative block cache with LRU
// replacement and per-slot reference counts.
// Request channel (req_): one transaction per command; req_tuser carries the
// mode, req_tdata the block number and slot index.
// Response channel (rsp_): one or more transactions per command, the final
// one with rsp_tlast high; rsp_tuser carries the result kind.
// Each command is worked by a sequencer around a single compare unit that
// visits one slot per cycle through registered tag, count and rank memories:
//   request: lookup pass, rank pass, then a victim store if one is due
//   write back, dirty query: lookup pass
//   release: read and write of the count; mark dirty and unknown modes: final result only
//   flush: check pass with one store per dirty slot, a final result if none
// req_tready is high only while the sequencer is idle, so one command is
// worked at a time. Results sit in an output register; the next command is
// taken while the last result of the previous one still waits. When the
// receiver stalls, the sequencer holds before loading the next result.
// Reset is synchronous: all slots become invalid, clean and unpinned, and the
// recency order returns to slot index order. No clearing pass is needed.
module pinned_lru_block_cache_control #(
   parameter int SLOTS = plc_pkg::SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] block_number, [36:32] slot, [39:37] zero
   input  logic [plc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] mode
   input  logic [plc_pkg::MODE_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [4:0] slot_res, [36:5] block_out, [37] dirty_answer, [39:38] zero
   output logic [plc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] kind
   output logic [plc_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [31:0] SLOTS_U32 = 32'(SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_DECIDE,
      ST_SWEEP,
      ST_SWEEP_TAIL,
      ST_EMIT_STORE,
      ST_EMIT_FINAL,
      ST_REL_RD,
      ST_REL_WR,
      ST_FL_CHECK,
      ST_FL_EMIT,
      ST_FL_END
   } state_type;

   // memories
   logic [plc_pkg::BLK_W-1:0] tag_mem  [SLOTS];
   logic [plc_pkg::CNT_W-1:0] cnt_mem  [SLOTS];
   logic [IDX_W-1:0]          rank_mem [SLOTS];

   logic [plc_pkg::BLK_W-1:0] tag_q_ff;
   logic [plc_pkg::CNT_W-1:0] cnt_q_ff;
   logic [IDX_W-1:0]          rank_q_ff;
   logic [IDX_W-1:0]          rd_addr;

   logic                      tag_we;
   logic [IDX_W-1:0]          tag_wa;
   logic                      cnt_we;
   logic [IDX_W-1:0]          cnt_wa;
   logic [plc_pkg::CNT_W-1:0] cnt_wd;
   logic                      rank_we;
   logic [IDX_W-1:0]          rank_wa;
   logic [IDX_W-1:0]          rank_wd;

   // per-slot flags
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] dirty_ff, dirty_in;
   logic [SLOTS-1:0] cnt_init_ff, cnt_init_in;
   logic [SLOTS-1:0] rank_init_ff, rank_init_in;

   state_type state_ff, state_in;

   logic [plc_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [plc_pkg::BLK_W-1:0]  blk_ff, blk_in;
   logic [plc_pkg::SLOT_W-1:0] sl_ff, sl_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             ev_vld_ff, ev_vld_in;
   logic             ev_sweep_ff, ev_sweep_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;

   logic                      hit_fnd_ff, hit_fnd_in;
   logic [IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]          hit_rank_ff, hit_rank_in;
   logic [plc_pkg::CNT_W-1:0] hit_cnt_ff, hit_cnt_in;

   logic                      vic_fnd_ff, vic_fnd_in;
   logic [IDX_W-1:0]          vic_idx_ff, vic_idx_in;
   logic [IDX_W-1:0]          vic_rank_ff, vic_rank_in;
   logic [plc_pkg::BLK_W-1:0] vic_tag_ff, vic_tag_in;
   logic                      st_pend_ff, st_pend_in;

   logic [IDX_W-1:0] tgt_idx_ff, tgt_idx_in;
   logic [IDX_W-1:0] tgt_rank_ff, tgt_rank_in;

   logic [plc_pkg::KIND_W-1:0] fin_kind_ff, fin_kind_in;
   logic [IDX_W-1:0]           fin_slot_ff, fin_slot_in;
   logic [plc_pkg::BLK_W-1:0]  fin_blk_ff, fin_blk_in;
   logic                       fin_dirty_ff, fin_dirty_in;
   logic                       stored_any_ff, stored_any_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [plc_pkg::KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [plc_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [plc_pkg::BLK_W-1:0]  rsp_blk_ff, rsp_blk_in;
   logic                       rsp_dirty_ff, rsp_dirty_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_acc;
   logic                       out_free;
   logic [plc_pkg::BLK_W-1:0]  req_blk;
   logic [plc_pkg::SLOT_W-1:0] req_sl;
   logic [IDX_W-1:0]           req_addr;
   logic                       req_in_range;
   logic [IDX_W-1:0]           sl_addr;
   logic                       sl_in_range;
   logic [plc_pkg::CNT_W-1:0]  ev_cnt;
   logic [IDX_W-1:0]           ev_rank;
   logic [SLOTS-1:0]           idx_onehot;
   logic [SLOTS-1:0]           dirty_left;

   assign req_blk      = req_tdata[plc_pkg::BLK_W-1:0];
   assign req_sl       = req_tdata[plc_pkg::BLK_W+plc_pkg::SLOT_W-1:plc_pkg::BLK_W];
   assign req_addr     = IDX_W'(req_sl);
   assign req_in_range = 32'(req_sl) < SLOTS_U32;
   assign sl_addr      = IDX_W'(sl_ff);
   assign sl_in_range  = 32'(sl_ff) < SLOTS_U32;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rd_addr = (state_ff == ST_REL_RD) ? sl_addr : idx_ff;

   // slots never written read as their reset values
   assign ev_cnt  = cnt_init_ff[ev_idx_ff] ? cnt_q_ff : '0;
   assign ev_rank = rank_init_ff[ev_idx_ff] ? rank_q_ff : ev_idx_ff;

   assign idx_onehot = SLOTS'(1) << idx_ff;
   assign dirty_left = valid_ff & dirty_ff & ~idx_onehot;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      blk_in        = blk_ff;
      sl_in         = sl_ff;
      idx_in        = idx_ff;
      ev_vld_in     = 1'b0;
      ev_sweep_in   = ev_sweep_ff;
      ev_idx_in     = ev_idx_ff;
      hit_fnd_in    = hit_fnd_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      hit_cnt_in    = hit_cnt_ff;
      vic_fnd_in    = vic_fnd_ff;
      vic_idx_in    = vic_idx_ff;
      vic_rank_in   = vic_rank_ff;
      vic_tag_in    = vic_tag_ff;
      st_pend_in    = st_pend_ff;
      tgt_idx_in    = tgt_idx_ff;
      tgt_rank_in   = tgt_rank_ff;
      fin_kind_in   = fin_kind_ff;
      fin_slot_in   = fin_slot_ff;
      fin_blk_in    = fin_blk_ff;
      fin_dirty_in  = fin_dirty_ff;
      stored_any_in = stored_any_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      cnt_init_in   = cnt_init_ff;
      rank_init_in  = rank_init_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      rsp_last_in   = rsp_last_ff;
      tag_we        = 1'b0;
      tag_wa        = vic_idx_ff;
      cnt_we        = 1'b0;
      cnt_wa        = ev_idx_ff;
      cnt_wd        = ev_cnt;
      rank_we       = 1'b0;
      rank_wa       = ev_idx_ff;
      rank_wd       = ev_rank;

      // shared compare unit: one slot per cycle
      if (ev_vld_ff && !ev_sweep_ff) begin
         if (!hit_fnd_ff && valid_ff[ev_idx_ff] && (tag_q_ff == blk_ff)) begin
            hit_fnd_in  = 1'b1;
            hit_idx_in  = ev_idx_ff;
            hit_rank_in = ev_rank;
            hit_cnt_in  = ev_cnt;
         end
         if ((ev_cnt == '0) && (!vic_fnd_ff || (ev_rank < vic_rank_ff))) begin
            vic_fnd_in  = 1'b1;
            vic_idx_in  = ev_idx_ff;
            vic_rank_in = ev_rank;
            vic_tag_in  = tag_q_ff;
         end
      end
      if (ev_vld_ff && ev_sweep_ff) begin
         rank_we = 1'b1;
         rank_init_in[ev_idx_ff] = 1'b1;
         if (ev_idx_ff == tgt_idx_ff) begin
            rank_wd = LAST_IDX;
         end else if (ev_rank > tgt_rank_ff) begin
            rank_wd = ev_rank - IDX_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in       = req_tuser;
               blk_in        = req_blk;
               sl_in         = req_sl;
               idx_in        = '0;
               hit_fnd_in    = 1'b0;
               vic_fnd_in    = 1'b0;
               stored_any_in = 1'b0;
               fin_kind_in   = plc_pkg::KIND_DONE;
               fin_slot_in   = '0;
               fin_blk_in    = '0;
               fin_dirty_in  = 1'b0;
               case (req_tuser)
                  plc_pkg::MODE_REQUEST,
                  plc_pkg::MODE_WRBACK,
                  plc_pkg::MODE_QUERY: state_in = ST_SCAN;
                  plc_pkg::MODE_RELEASE: state_in = ST_REL_RD;
                  plc_pkg::MODE_FLUSH: state_in = ST_FL_CHECK;
                  plc_pkg::MODE_MARK: begin
                     if (req_in_range && valid_ff[req_addr]) begin
                        dirty_in[req_addr] = 1'b1;
                     end
                     state_in = ST_EMIT_FINAL;
                  end
                  default: state_in = ST_EMIT_FINAL;
               endcase
            end
         end
         ST_SCAN: begin
            ev_vld_in   = 1'b1;
            ev_sweep_in = 1'b0;
            ev_idx_in   = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCAN_TAIL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SCAN_TAIL: state_in = ST_DECIDE;
         ST_DECIDE: begin
            idx_in     = '0;
            st_pend_in = 1'b0;
            fin_blk_in = blk_ff;
            state_in   = ST_EMIT_FINAL;
            case (mode_ff)
               plc_pkg::MODE_REQUEST: begin
                  if (hit_fnd_ff) begin
                     cnt_we  = 1'b1;
                     cnt_wa  = hit_idx_ff;
                     cnt_wd  = (hit_cnt_ff == plc_pkg::CNT_MAX) ? hit_cnt_ff
                                                                : hit_cnt_ff + 16'd1;
                     cnt_init_in[hit_idx_ff] = 1'b1;
                     tgt_idx_in  = hit_idx_ff;
                     tgt_rank_in = hit_rank_ff;
                     fin_kind_in = plc_pkg::KIND_HIT;
                     fin_slot_in = hit_idx_ff;
                     state_in    = ST_SWEEP;
                  end else if (!vic_fnd_ff) begin
                     fin_kind_in = plc_pkg::KIND_ERROR;
                     fin_slot_in = '0;
                  end else begin
                     st_pend_in = valid_ff[vic_idx_ff] && dirty_ff[vic_idx_ff];
                     tag_we     = 1'b1;
                     tag_wa     = vic_idx_ff;
                     valid_in[vic_idx_ff] = 1'b1;
                     dirty_in[vic_idx_ff] = 1'b0;
                     cnt_we     = 1'b1;
                     cnt_wa     = vic_idx_ff;
                     cnt_wd     = 16'd1;
                     cnt_init_in[vic_idx_ff] = 1'b1;
                     tgt_idx_in  = vic_idx_ff;
                     tgt_rank_in = vic_rank_ff;
                     fin_kind_in = plc_pkg::KIND_LOAD;
                     fin_slot_in = vic_idx_ff;
                     state_in    = ST_SWEEP;
                  end
               end
               plc_pkg::MODE_WRBACK: begin
                  if (hit_fnd_ff && dirty_ff[hit_idx_ff]) begin
                     dirty_in[hit_idx_ff] = 1'b0;
                     fin_kind_in = plc_pkg::KIND_STORE;
                     fin_slot_in = hit_idx_ff;
                  end else begin
                     fin_kind_in = plc_pkg::KIND_DONE;
                     fin_slot_in = '0;
                     fin_blk_in  = '0;
                  end
               end
               plc_pkg::MODE_QUERY: begin
                  fin_kind_in  = plc_pkg::KIND_QUERY;
                  fin_slot_in  = hit_fnd_ff ? hit_idx_ff : '0;
                  fin_dirty_in = hit_fnd_ff && dirty_ff[hit_idx_ff];
               end
               default: begin
                  fin_kind_in = plc_pkg::KIND_DONE;
                  fin_slot_in = '0;
                  fin_blk_in  = '0;
               end
            endcase
         end
         ST_SWEEP: begin
            ev_vld_in   = 1'b1;
            ev_sweep_in = 1'b1;
            ev_idx_in   = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SWEEP_TAIL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SWEEP_TAIL: state_in = st_pend_ff ? ST_EMIT_STORE : ST_EMIT_FINAL;
         ST_EMIT_STORE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = plc_pkg::KIND_STORE;
               rsp_slot_in  = plc_pkg::SLOT_W'(vic_idx_ff);
               rsp_blk_in   = vic_tag_ff;
               rsp_dirty_in = 1'b0;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT_FINAL;
            end
         end
         ST_EMIT_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = fin_kind_ff;
               rsp_slot_in  = plc_pkg::SLOT_W'(fin_slot_ff);
               rsp_blk_in   = fin_blk_ff;
               rsp_dirty_in = fin_dirty_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REL_RD: begin
            ev_idx_in = sl_addr;
            state_in  = ST_REL_WR;
         end
         ST_REL_WR: begin
            if (sl_in_range && (ev_cnt != '0)) begin
               cnt_we = 1'b1;
               cnt_wa = ev_idx_ff;
               cnt_wd = ev_cnt - 16'd1;
               cnt_init_in[ev_idx_ff] = 1'b1;
            end
            state_in = ST_EMIT_FINAL;
         end
         ST_FL_CHECK: begin
            if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
               state_in = ST_FL_EMIT;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_FL_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FL_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = plc_pkg::KIND_STORE;
               rsp_slot_in      = plc_pkg::SLOT_W'(idx_ff);
               rsp_blk_in       = tag_q_ff;
               rsp_dirty_in     = 1'b0;
               rsp_last_in      = (dirty_left == '0);
               dirty_in[idx_ff] = 1'b0;
               stored_any_in    = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FL_END;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_FL_CHECK;
               end
            end
         end
         ST_FL_END: begin
            valid_in = '0;
            dirty_in = '0;
            state_in = stored_any_ff ? ST_IDLE : ST_EMIT_FINAL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         cnt_init_ff  <= '0;
         rank_init_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ev_vld_ff    <= ev_vld_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         cnt_init_ff  <= cnt_init_in;
         rank_init_ff <= rank_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      blk_ff        <= blk_in;
      sl_ff         <= sl_in;
      idx_ff        <= idx_in;
      ev_sweep_ff   <= ev_sweep_in;
      ev_idx_ff     <= ev_idx_in;
      hit_fnd_ff    <= hit_fnd_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rank_ff   <= hit_rank_in;
      hit_cnt_ff    <= hit_cnt_in;
      vic_fnd_ff    <= vic_fnd_in;
      vic_idx_ff    <= vic_idx_in;
      vic_rank_ff   <= vic_rank_in;
      vic_tag_ff    <= vic_tag_in;
      st_pend_ff    <= st_pend_in;
      tgt_idx_ff    <= tgt_idx_in;
      tgt_rank_ff   <= tgt_rank_in;
      fin_kind_ff   <= fin_kind_in;
      fin_slot_ff   <= fin_slot_in;
      fin_blk_ff    <= fin_blk_in;
      fin_dirty_ff  <= fin_dirty_in;
      stored_any_ff <= stored_any_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_dirty_ff  <= rsp_dirty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= blk_ff;
      end
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (rank_we) begin
         rank_mem[rank_wa] <= rank_wd;
      end
      tag_q_ff  <= tag_mem[rd_addr];
      cnt_q_ff  <= cnt_mem[rd_addr];
      rank_q_ff <= rank_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_dirty_ff, rsp_blk_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after a command was taken");

   a_final_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_FINAL) && rsp_valid_ff && !rsp_tready
         |=> (state_ff == ST_EMIT_FINAL))
      else $error("final result loaded while the output register was full");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FL_END) |=> (valid_ff == '0) && (dirty_ff == '0))
      else $error("flush left a valid or dirty slot");

   a_only_store_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> (rsp_kind_ff == plc_pkg::KIND_STORE))
      else $error("non-final result that is not a store");

   a_load_slot_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == plc_pkg::KIND_LOAD) && (state_ff == ST_IDLE)
         |-> valid_ff[vic_idx_ff])
      else $error("load issued for a slot that is not valid");

endmodule

// ===== tb/plc_test_pkg.sv =====
package plc_test_pkg;
   import plc_pkg::*;

   localparam int NSLOTS = SLOTS_DEF;

   // modes the block has to ignore
   localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [BLK_W-1:0]  blk;
      logic              dirty;
      logic              last;
   } cache_result_type;

   // shadow of the tag store plus the queue of results it predicts
   class slot_table_scoreboard;
      logic [BLK_W-1:0] tag_blk [NSLOTS];
      bit               valid_q [NSLOTS];
      bit               dirty_q [NSLOTS];
      logic [CNT_W-1:0] pin_cnt [NSLOTS];
      int               age     [NSLOTS];
      cache_result_type expected_q[$];
      int               errors;

      function new();
         errors = 0;
         for (int i = 0; i < NSLOTS; i++) begin
            tag_blk[i] = '0;
            valid_q[i] = 1'b0;
            dirty_q[i] = 1'b0;
            pin_cnt[i] = '0;
            age[i]     = i;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int find(logic [BLK_W-1:0] blk);
         for (int i = 0; i < NSLOTS; i++)
            if (valid_q[i] && tag_blk[i] == blk)
               return i;
         return -1;
      endfunction

      // random slot that is pinned, or valid; -1 if there is none
      function int any_slot(bit want_pinned);
         int cand[$];
         for (int i = 0; i < NSLOTS; i++)
            if (want_pinned ? (pin_cnt[i] != 0) : valid_q[i])
               cand.push_back(i);
         if (cand.size() == 0)
            return -1;
         return cand[$urandom_range(cand.size() - 1)];
      endfunction

      function void touch(int s);
         for (int j = 0; j < NSLOTS; j++)
            if (age[j] > age[s])
               age[j]--;
         age[s] = NSLOTS - 1;
      endfunction

      function void queue_result(logic [KIND_W-1:0] kind, int s, logic [BLK_W-1:0] blk,
                                 logic dirty, logic last);
         cache_result_type r;
         r.kind  = kind;
         r.slot  = s[SLOT_W-1:0];
         r.blk   = blk;
         r.dirty = dirty;
         r.last  = last;
         expected_q.push_back(r);
      endfunction

      function void take_command(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] blk,
                                 logic [SLOT_W-1:0] sl);
         int s;
         int last_dirty;
         s = -1;
         last_dirty = -1;
         case (mode)
            MODE_REQUEST: begin
               s = find(blk);
               if (s >= 0) begin
                  touch(s);
                  if (pin_cnt[s] != CNT_MAX)
                     pin_cnt[s]++;
                  queue_result(KIND_HIT, s, blk, 1'b0, 1'b1);
                  return;
               end
               // victim: least recent slot that nobody holds
               for (int i = 0; i < NSLOTS; i++)
                  if (pin_cnt[i] == 0 && (s < 0 || age[i] < age[s]))
                     s = i;
               if (s < 0) begin
                  queue_result(KIND_ERROR, 0, blk, 1'b0, 1'b1);
                  return;
               end
               if (valid_q[s] && dirty_q[s])
                  queue_result(KIND_STORE, s, tag_blk[s], 1'b0, 1'b0);
               tag_blk[s] = blk;
               valid_q[s] = 1'b1;
               dirty_q[s] = 1'b0;
               pin_cnt[s] = CNT_W'(1);
               touch(s);
               queue_result(KIND_LOAD, s, blk, 1'b0, 1'b1);
               return;
            end
            MODE_RELEASE: begin
               if (int'(sl) < NSLOTS && pin_cnt[sl] != 0)
                  pin_cnt[sl]--;
            end
            MODE_WRBACK: begin
               s = find(blk);
               if (s >= 0 && dirty_q[s]) begin
                  dirty_q[s] = 1'b0;
                  queue_result(KIND_STORE, s, tag_blk[s], 1'b0, 1'b1);
                  return;
               end
            end
            MODE_FLUSH: begin
               for (int i = 0; i < NSLOTS; i++)
                  if (valid_q[i] && dirty_q[i])
                     last_dirty = i;
               // counts and ranks survive, tags do not
               for (int i = 0; i < NSLOTS; i++) begin
                  if (valid_q[i] && dirty_q[i])
                     queue_result(KIND_STORE, i, tag_blk[i], 1'b0, i == last_dirty);
                  valid_q[i] = 1'b0;
                  dirty_q[i] = 1'b0;
                  tag_blk[i] = '0;
               end
               if (last_dirty >= 0)
                  return;
            end
            MODE_QUERY: begin
               s = find(blk);
               if (s >= 0)
                  queue_result(KIND_QUERY, s, blk, dirty_q[s], 1'b1);
               else
                  queue_result(KIND_QUERY, 0, blk, 1'b0, 1'b1);
               return;
            end
            MODE_MARK: begin
               if (int'(sl) < NSLOTS && valid_q[sl])
                  dirty_q[sl] = 1'b1;
            end
            default: ;
         endcase
         queue_result(KIND_DONE, 0, '0, 1'b0, 1'b1);
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                        logic [BLK_W-1:0] blk, logic dirty, logic last);
         cache_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing pending: kind %0d slot %0d block %h",
                             kind, slot, blk));
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind %0d, want %0d", kind, want.kind));
         if (slot !== want.slot)
            report($sformatf("slot %0d, want %0d (kind %0d)", slot, want.slot, want.kind));
         if (blk !== want.blk)
            report($sformatf("block %h, want %h (kind %0d)", blk, want.blk, want.kind));
         if (dirty !== want.dirty)
            report($sformatf("dirty %b, want %b (kind %0d)", dirty, want.dirty, want.kind));
         if (last !== want.last)
            report($sformatf("last %b, want %b (kind %0d)", last, want.last, want.kind));
      endtask
   endclass

endpackage

// ===== tb/pinned_lru_block_cache_control_test.sv =====
module pinned_lru_block_cache_control_test;
   timeunit 1ns;
   timeprecision 1ps;
   import plc_pkg::*;
   import plc_test_pkg::*;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   slot_table_scoreboard sb = new();

   logic [BLK_W-1:0] block_pool [48];
   int               burst_left = 0;
   bit               steady     = 1'b0;
   rx_style_type     rx_style   = RX_OPEN;
   int               rx_left    = 0;

   pinned_lru_block_cache_control u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver back-pressure in random styles: open, coin toss, sparse, periodic
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_style <= rx_style_type'($urandom_range(3));
         rx_left  <= $urandom_range(40, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_style)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(1));
         RX_SPARSE: rsp_tready <= ($urandom_range(3) == 0);
         default:   rsp_tready <= (rx_left % 16) < 6;
      endcase
   end

   // check results before noting a command taken on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[4:0], rsp_tdata[36:5], rsp_tdata[37],
                            rsp_tlast);
         if (req_tvalid && req_tready)
            sb.take_command(req_tuser, req_tdata[31:0], req_tdata[36:32]);
      end
   end

   task automatic pace();
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!steady) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   endtask

   task automatic send_cmd(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] blk,
                           logic [SLOT_W-1:0] sl);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      // [31:0] block, [36:32] slot, pad zero
      req_tdata  <= {3'b000, sl, blk};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pace();
   endtask

   // hold off the sender until every pending result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic random_command(bit pin_heavy);
      int               pick;
      int               s;
      int               t_req, t_rel, t_mark, t_wb, t_qry, t_fl;
      logic [BLK_W-1:0] blk;
      logic [SLOT_W-1:0] sl;
      if (pin_heavy) begin
         t_req = 75; t_rel = 80; t_mark = 88; t_wb = 92; t_qry = 97; t_fl = 97;
      end else begin
         t_req = 40; t_rel = 65; t_mark = 75; t_wb = 85; t_qry = 95; t_fl = 97;
      end
      pick = $urandom_range(99);
      blk  = $urandom();
      sl   = SLOT_W'($urandom_range(31));
      if (pick < t_req) begin
         // mostly new blocks while pinning, mostly the pool otherwise
         if (pin_heavy ? ($urandom_range(4) == 0) : ($urandom_range(19) < 17))
            blk = block_pool[$urandom_range(47)];
         send_cmd(MODE_REQUEST, blk, sl);
      end else if (pick < t_mark) begin
         s = sb.any_slot(pick < t_rel);
         if (s >= 0 && $urandom_range(4) != 0)
            sl = s[SLOT_W-1:0];
         send_cmd((pick < t_rel) ? MODE_RELEASE : MODE_MARK, blk, sl);
      end else if (pick < t_qry) begin
         s = sb.any_slot(1'b0);
         if (s >= 0 && $urandom_range(2) != 0)
            blk = sb.tag_blk[s];
         else
            blk = block_pool[$urandom_range(47)];
         send_cmd((pick < t_wb) ? MODE_WRBACK : MODE_QUERY, blk, sl);
      end else if (pick < t_fl) begin
         send_cmd(MODE_FLUSH, blk, sl);
      end else begin
         send_cmd($urandom_range(1) ? MODE_RSVD_A : MODE_RSVD_B, blk, sl);
      end
   endtask

   initial begin
      bit heavy;
      for (int i = 0; i < 48; i++)
         block_pool[i] = $urandom();
      block_pool[0] = '0;
      block_pool[1] = '1;
      block_pool[2] = 32'd1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      steady = 1'b1;
      // block zero is empty only by its valid mark
      send_cmd(MODE_QUERY,   32'h0,          5'd0);
      send_cmd(MODE_REQUEST, 32'h0,          5'd31);
      send_cmd(MODE_REQUEST, 32'hFFFF_FFFF,  5'd0);
      send_cmd(MODE_REQUEST, 32'h0,          5'd0);
      send_cmd(MODE_MARK,    32'h0,          SLOT_W'(sb.find(32'h0)));
      send_cmd(MODE_QUERY,   32'h0,          5'd31);
      send_cmd(MODE_WRBACK,  32'hFFFF_FFFF,  5'd0);
      send_cmd(MODE_WRBACK,  32'h0,          5'd0);
      send_cmd(MODE_WRBACK,  32'h1,          5'd0);
      send_cmd(MODE_MARK,    32'h0,          SLOT_W'(sb.find(32'hFFFF_FFFF)));
      send_cmd(MODE_MARK,    32'hFFFF_FFFF,  5'd31);
      send_cmd(MODE_RELEASE, 32'hFFFF_FFFF,  5'd31);
      repeat (3) send_cmd(MODE_RELEASE, 32'h0, SLOT_W'(sb.find(32'h0)));
      send_cmd(MODE_RSVD_A,  32'hFFFF_FFFF,  5'd31);
      send_cmd(MODE_RSVD_B,  32'h0,          5'd0);
      send_cmd(MODE_QUERY,   32'hFFFF_FFFF,  5'd0);
      send_cmd(MODE_FLUSH,   32'h0,          5'd0);
      send_cmd(MODE_FLUSH,   32'hFFFF_FFFF,  5'd31);
      send_cmd(MODE_QUERY,   32'hFFFF_FFFF,  5'd0);
      send_cmd(MODE_REQUEST, 32'h8000_0000,  5'd0);
      send_cmd(MODE_REQUEST, 32'h5A5A_5A5A,  5'd0);
      send_cmd(MODE_REQUEST, 32'h8000_0000,  5'd0);
      drain();

      // a few segments pin nearly every slot to provoke the no-free-slot error
      for (int seg = 0; seg < 7; seg++) begin
         heavy  = (seg == 2 || seg == 5 || $urandom_range(4) == 0);
         steady = ($urandom_range(3) == 0);
         repeat (50) random_command(heavy);
         drain();
      end

      repeat (100) @(negedge clock);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/plc_pkg.sv
hdl/pinned_lru_block_cache_control.sv
tb/plc_test_pkg.sv
tb/pinned_lru_block_cache_control_test.sv
